/* rtl/aarp_pkg.sv */
// Shared types and constants for the address resolution cache.
package aarp_pkg;

    localparam logic [3:0] ACT_KNOWN    = 4'd0;
    localparam logic [3:0] ACT_MCAST    = 4'd1;
    localparam logic [3:0] ACT_HELD     = 4'd2;
    localparam logic [3:0] ACT_REF_PEND = 4'd3;
    localparam logic [3:0] ACT_REF_FULL = 4'd4;
    localparam logic [3:0] ACT_QUERY    = 4'd5;
    localparam logic [3:0] ACT_RELEASE  = 4'd6;
    localparam logic [3:0] ACT_DROP     = 4'd7;
    localparam logic [3:0] ACT_REPLY    = 4'd8;
    localparam logic [3:0] ACT_NONE     = 4'd9;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_RESP    = 2'd1;
    localparam logic [1:0] KIND_REQ     = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    localparam logic [2:0] CFG_REFRESH  = 3'd0;
    localparam logic [2:0] CFG_RESOLVE  = 3'd1;
    localparam logic [2:0] CFG_RETRY    = 3'd2;
    localparam logic [2:0] CFG_OWN_NET  = 3'd3;
    localparam logic [2:0] CFG_OWN_NODE = 3'd4;

    localparam logic [47:0] MCAST_HW    = 48'h0900_07FF_FFFF;

    // per-slot compare results
    typedef struct packed {
        logic live;
        logic resolved;
        logic match;
        logic expired;
        logic tries_lt;
    } t_slot_eval;

endpackage

/* rtl/aarp_slot_cmp.sv */
// Compare unit shared by every pass over the table slots.
module aarp_slot_cmp
    import aarp_pkg::*;
(
    input  logic        i_valid,
    input  logic        i_resolved,
    input  logic [15:0] i_ent_net,
    input  logic [7:0]  i_ent_node,
    input  logic [31:0] i_ent_expiry,
    input  logic [3:0]  i_ent_tries,
    input  logic [15:0] i_key_net,
    input  logic [7:0]  i_key_node,
    input  logic [31:0] i_now,
    input  logic [3:0]  i_limit,
    output t_slot_eval  o_eval
);

    always_comb begin
        o_eval.live     = i_valid;
        o_eval.resolved = i_resolved;
        o_eval.match    = i_valid && (i_ent_net == i_key_net) && (i_ent_node == i_key_node);
        o_eval.expired  = i_ent_expiry < i_now;
        o_eval.tries_lt = i_ent_tries < i_limit;
    end

endmodule

/* rtl/aarp_address_resolution_cache.sv */
// Top level: table storage, slot sequencer and output register.
// Every request first scans all ENTRIES slots (one per cycle), then emits.
// Send/response/request then emit one result (a send that allocates a new entry
// adds its query after it); a tick makes a second pass emitting queries and drops,
// with an extra step per slot queried and then dropped, then a final result. Output
// stalls hold the flow; ready again the cycle after the last result; reset clears the state and valid bits.
module aarp_address_resolution_cache
    import aarp_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // peer_net[15:0] peer_node[23:16] peer_hw[71:24] asked_net[87:72]
    // asked_node[95:88] now_seconds[127:96]
    input  logic [127:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot[3:0] dest_hw[51:4] target_net[67:52] target_node[75:68]
    // any_pending[76] zero[79:77]
    output logic [79:0]  m_axis_tdata,
    // action[3:0]
    output logic [3:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_QUERY  = 3'd3;
    localparam logic [2:0] ST_TICK   = 3'd4;
    localparam logic [2:0] ST_TDROP  = 3'd5;
    localparam logic [2:0] ST_FINAL  = 3'd6;

    logic [15:0] r_refresh, r_resolve, r_own_net;
    logic [3:0]  r_retry;
    logic [7:0]  r_own_node;

    logic [15:0] mem_net    [ENTRIES];
    logic [7:0]  mem_node   [ENTRIES];
    logic [47:0] mem_hw     [ENTRIES];
    logic [31:0] mem_expiry [ENTRIES];
    logic [3:0]  mem_tries  [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid, r_resolved, n_resolved;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [1:0]    r_kind;
    logic [15:0]   r_pnet, r_anet;
    logic [7:0]    r_pnode, r_anode;
    logic [47:0]   r_phw;
    logic [31:0]   r_now;

    logic r_fres, n_fres, r_fpend, n_fpend, r_ffree, n_ffree;
    logic r_pbefore, n_pbefore, r_pother, n_pother, r_ptick, n_ptick;
    logic [IW-1:0] r_sres, n_sres, r_spend, n_spend, r_sfree, n_sfree;

    logic        r_ovalid;
    logic [3:0]  r_oact, r_oslot;
    logic [47:0] r_ohw;
    logic [15:0] r_onet;
    logic [7:0]  r_onode;
    logic        r_opend, r_olast;

    logic        accept, can_emit;
    logic        e_go, e_last;
    logic [3:0]  e_act;
    logic [IW-1:0] e_slot;
    logic [47:0] e_hw;
    logic [15:0] e_net;
    logic [7:0]  e_node;
    logic        e_pend;

    logic [IW-1:0] w_ra, w_wa;
    logic we_key, we_hw, we_exp, we_tries;
    logic [31:0] w_exp;
    logic [3:0]  w_tries;
    t_slot_eval  ev;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign can_emit = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_ra = (r_state == ST_DECIDE) ? r_sres : r_idx;

    aarp_slot_cmp u_cmp (
        .i_valid      (r_valid[w_ra]),
        .i_resolved   (r_resolved[w_ra]),
        .i_ent_net    (mem_net[w_ra]),
        .i_ent_node   (mem_node[w_ra]),
        .i_ent_expiry (mem_expiry[w_ra]),
        .i_ent_tries  (mem_tries[w_ra]),
        .i_key_net    (r_pnet),
        .i_key_node   (r_pnode),
        .i_now        (r_now),
        .i_limit      (r_retry),
        .o_eval       (ev)
    );

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh  <= 16'd300;
            r_resolve  <= 16'd10;
            r_retry    <= 4'd10;
            r_own_net  <= 16'd0;
            r_own_node <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REFRESH:  r_refresh  <= i_cfg_data;
                CFG_RESOLVE:  r_resolve  <= i_cfg_data;
                CFG_RETRY:    r_retry    <= i_cfg_data[3:0];
                CFG_OWN_NET:  r_own_net  <= i_cfg_data;
                CFG_OWN_NODE: r_own_node <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;   n_idx = r_idx;
        n_valid = r_valid;   n_resolved = r_resolved;
        n_fres = r_fres;     n_sres = r_sres;
        n_fpend = r_fpend;   n_spend = r_spend;
        n_ffree = r_ffree;   n_sfree = r_sfree;
        n_pbefore = r_pbefore; n_pother = r_pother; n_ptick = r_ptick;
        e_go = 1'b0; e_last = 1'b0; e_act = ACT_NONE; e_slot = '0;
        e_hw = '0; e_net = '0; e_node = '0;
        e_pend = r_pbefore;
        w_wa = r_idx;
        we_key = 1'b0; we_hw = 1'b0; we_exp = 1'b0; we_tries = 1'b0;
        w_exp = r_now + {16'd0, r_refresh};
        w_tries = (mem_tries[w_ra] == 4'hF) ? 4'hF : mem_tries[w_ra] + 4'd1;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN; n_idx = '0;
                    n_fres = 1'b0; n_fpend = 1'b0; n_ffree = 1'b0;
                    n_pbefore = 1'b0; n_pother = 1'b0; n_ptick = 1'b0;
                end
            end
            ST_SCAN: begin
                if (ev.match && ev.resolved && !r_fres) begin
                    n_fres = 1'b1; n_sres = r_idx;
                end
                if (ev.live && !ev.resolved) begin
                    n_pbefore = 1'b1;
                    if (ev.match && !r_fpend) begin
                        n_fpend = 1'b1; n_spend = r_idx;
                    end else begin
                        n_pother = 1'b1;
                    end
                    if (ev.tries_lt && !ev.expired)
                        n_ptick = 1'b1;
                end
                if (!ev.live && !r_ffree) begin
                    n_ffree = 1'b1; n_sfree = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    n_state = (r_kind == KIND_TICK) ? ST_TICK : ST_DECIDE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_DECIDE: begin
                if (can_emit) begin
                    e_go = 1'b1; e_last = 1'b1; n_state = ST_IDLE;
                    case (r_kind)
                        KIND_SEND: begin
                            if (r_pnode == 8'hFF) begin
                                e_act = ACT_MCAST; e_hw = MCAST_HW;
                            end else if (r_fres) begin
                                e_act = ACT_KNOWN; e_slot = r_sres; e_hw = mem_hw[w_ra];
                                w_wa = r_sres; we_exp = 1'b1;
                            end else if (r_fpend) begin
                                e_act = ACT_REF_PEND; e_slot = r_spend;
                            end else if (r_ffree) begin
                                // new pending entry; its first query follows
                                e_act = ACT_HELD; e_slot = r_sfree; e_last = 1'b0;
                                e_pend = 1'b1;
                                w_wa = r_sfree; we_key = 1'b1; we_exp = 1'b1;
                                we_tries = 1'b1; w_tries = 4'd1;
                                w_exp = r_now + {16'd0, r_resolve};
                                n_valid[r_sfree] = 1'b1; n_resolved[r_sfree] = 1'b0;
                                n_state = ST_QUERY;
                            end else begin
                                e_act = ACT_REF_FULL;
                            end
                        end
                        KIND_RESP: begin
                            if (r_fpend) begin
                                e_act = ACT_RELEASE; e_slot = r_spend; e_hw = r_phw;
                                e_pend = r_pother;
                                w_wa = r_spend; we_hw = 1'b1;
                                n_resolved[r_spend] = 1'b1;
                            end
                        end
                        KIND_REQ: begin
                            if ((r_anode == r_own_node) && !(r_anet != 16'd0 &&
                                r_own_net != 16'd0 && r_anet != r_own_net)) begin
                                e_act = ACT_REPLY; e_hw = r_phw;
                                e_net = r_pnet; e_node = r_pnode;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_QUERY: begin
                if (can_emit) begin
                    e_go = 1'b1; e_last = 1'b1; e_act = ACT_QUERY; e_slot = r_sfree;
                    e_net = r_pnet; e_node = r_pnode; e_pend = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK, ST_TDROP: begin
                e_pend = r_ptick;
                e_slot = r_idx;
                if (r_state == ST_TDROP || (ev.live && !ev.resolved && !ev.tries_lt)) begin
                    if (can_emit) begin
                        e_go = 1'b1; e_act = ACT_DROP;
                        n_valid[r_idx] = 1'b0;
                        n_idx = r_idx + IW'(1);
                        n_state = (r_idx == LAST_IDX) ? ST_FINAL : ST_TICK;
                    end
                end else if (ev.live && !ev.resolved) begin
                    if (can_emit) begin
                        e_go = 1'b1; e_act = ACT_QUERY;
                        e_net = mem_net[w_ra]; e_node = mem_node[w_ra];
                        we_tries = 1'b1;
                        if (ev.expired) begin
                            n_state = ST_TDROP;
                        end else begin
                            n_idx = r_idx + IW'(1);
                            n_state = (r_idx == LAST_IDX) ? ST_FINAL : ST_TICK;
                        end
                    end
                end else begin
                    if (ev.live && ev.expired) begin
                        n_valid[r_idx] = 1'b0; n_resolved[r_idx] = 1'b0;
                    end
                    n_idx = r_idx + IW'(1);
                    n_state = (r_idx == LAST_IDX) ? ST_FINAL : ST_TICK;
                end
            end
            ST_FINAL: begin
                if (can_emit) begin
                    e_go = 1'b1; e_last = 1'b1; e_pend = r_ptick; n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (we_key) begin
            mem_net[w_wa]  <= r_pnet;
            mem_node[w_wa] <= r_pnode;
        end
        if (we_hw)    mem_hw[w_wa]     <= r_phw;
        if (we_exp)   mem_expiry[w_wa] <= w_exp;
        if (we_tries) mem_tries[w_wa]  <= w_tries;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_resolved <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_resolved <= n_resolved;
            if (e_go)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_fres <= n_fres;   r_sres <= n_sres;
        r_fpend <= n_fpend; r_spend <= n_spend;
        r_ffree <= n_ffree; r_sfree <= n_sfree;
        r_pbefore <= n_pbefore; r_pother <= n_pother; r_ptick <= n_ptick;
        if (accept) begin
            r_kind  <= s_axis_tuser;
            r_pnet  <= s_axis_tdata[15:0];
            r_pnode <= s_axis_tdata[23:16];
            r_phw   <= s_axis_tdata[71:24];
            r_anet  <= s_axis_tdata[87:72];
            r_anode <= s_axis_tdata[95:88];
            r_now   <= s_axis_tdata[127:96];
        end
        if (e_go) begin
            r_oact  <= e_act;
            r_oslot <= 4'(e_slot);
            r_ohw   <= e_hw;
            r_onet  <= e_net;
            r_onode <= e_node;
            r_opend <= e_pend;
            r_olast <= e_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_oact;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, r_opend, r_onode, r_onet, r_ohw, r_oslot};

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_go && e_last |=> r_state == ST_IDLE)
        else $error("final result did not return to idle");
    a_res_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_resolved & ~r_valid) == '0)
        else $error("resolved bit set on a free slot");
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_SCAN && r_idx == '0)
        else $error("scan did not start at slot zero");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_go |-> can_emit)
        else $error("result overwrote a waiting result");

endmodule

/* tb/tb_aarp_address_resolution_cache.sv */
// Testbench for the address resolution cache: scripted and random requests against a predictor.
module tb_aarp_address_resolution_cache;
    import aarp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  slot;
        logic [47:0] dest_hw;
        logic [15:0] target_net;
        logic [7:0]  target_node;
        logic        any_pending;
        logic        last;
    } t_outcome;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    aarp_address_resolution_cache #(.ENTRIES(ENTRIES)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] refresh_s, resolve_s, own_net_r;
    logic [3:0]  retry_lim;
    logic [7:0]  own_node_r;
    logic        ent_valid [ENTRIES];
    logic        ent_res [ENTRIES];
    logic [15:0] ent_net [ENTRIES];
    logic [7:0]  ent_node [ENTRIES];
    logic [47:0] ent_hw [ENTRIES];
    logic [31:0] ent_exp [ENTRIES];
    logic [3:0]  ent_tries [ENTRIES];

    t_outcome expected_outcomes[$];
    t_outcome step_buf[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    logic [15:0] recent_net[$];
    logic [7:0]  recent_node[$];

    function automatic void emit(logic [3:0] act, int slot, logic [47:0] hw,
                                 logic [15:0] net, logic [7:0] node);
        t_outcome o;
        o.action = act; o.slot = slot[3:0]; o.dest_hw = hw;
        o.target_net = net; o.target_node = node; o.any_pending = 1'b0; o.last = 1'b0;
        step_buf.push_back(o);
    endfunction

    function automatic int lookup(logic [15:0] net, logic [7:0] node, logic res);
        for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && ent_res[i] == res && ent_net[i] == net &&
                ent_node[i] == node)
                return i;
        return -1;
    endfunction

    function automatic void send_query(int i);
        if (ent_tries[i] < 4'd15) ent_tries[i]++;
        emit(ACT_QUERY, i, '0, ent_net[i], ent_node[i]);
    endfunction

    function automatic void predict_request(logic [1:0] kind, logic [15:0] pnet,
            logic [7:0] pnode, logic [47:0] phw, logic [15:0] anet,
            logic [7:0] anode, logic [31:0] now);
        int i;
        int ir;
        int ip;
        logic pend;
        step_buf.delete();
        if (kind == KIND_SEND) begin
            ir = lookup(pnet, pnode, 1'b1);
            ip = lookup(pnet, pnode, 1'b0);
            if (pnode == 8'hFF) emit(ACT_MCAST, 0, MCAST_HW, '0, '0);
            else if (ir >= 0) begin
                ent_exp[ir] = now + {16'd0, refresh_s};
                emit(ACT_KNOWN, ir, ent_hw[ir], '0, '0);
            end else if (ip >= 0)
                emit(ACT_REF_PEND, ip, '0, '0, '0);
            else begin
                for (i = 0; i < ENTRIES && ent_valid[i]; i++) ;
                if (i >= ENTRIES) emit(ACT_REF_FULL, 0, '0, '0, '0);
                else begin
                    ent_valid[i] = 1'b1; ent_res[i] = 1'b0; ent_net[i] = pnet;
                    ent_node[i] = pnode; ent_hw[i] = '0;
                    ent_exp[i] = now + {16'd0, resolve_s}; ent_tries[i] = '0;
                    emit(ACT_HELD, i, '0, '0, '0);
                    send_query(i);
                end
            end
        end else if (kind == KIND_RESP) begin
            i = lookup(pnet, pnode, 1'b0);
            if (i >= 0) begin
                ent_hw[i] = phw; ent_res[i] = 1'b1;
                emit(ACT_RELEASE, i, phw, '0, '0);
            end else emit(ACT_NONE, 0, '0, '0, '0);
        end else if (kind == KIND_REQ) begin
            if (anode == own_node_r &&
                !(anet != 0 && own_net_r != 0 && anet != own_net_r))
                emit(ACT_REPLY, 0, phw, pnet, pnode);
            else emit(ACT_NONE, 0, '0, '0, '0);
        end else begin
            for (i = 0; i < ENTRIES; i++) begin
                if (!ent_valid[i]) continue;
                if (ent_res[i]) begin
                    if (ent_exp[i] < now) ent_valid[i] = 1'b0;
                    continue;
                end
                if (ent_tries[i] >= retry_lim) begin
                    ent_valid[i] = 1'b0;
                    emit(ACT_DROP, i, '0, '0, '0);
                    continue;
                end
                send_query(i);
                if (ent_exp[i] < now) begin
                    ent_valid[i] = 1'b0;
                    emit(ACT_DROP, i, '0, '0, '0);
                end
            end
            emit(ACT_NONE, 0, '0, '0, '0);
        end
        pend = 1'b0;
        for (i = 0; i < ENTRIES; i++) if (ent_valid[i] && !ent_res[i]) pend = 1'b1;
        foreach (step_buf[k]) begin
            step_buf[k].any_pending = pend;
            step_buf[k].last = (k == step_buf.size() - 1);
            expected_outcomes.push_back(step_buf[k]);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(logic [1:0] kind, logic [15:0] pnet, logic [7:0] pnode,
            logic [47:0] phw, logic [15:0] anet, logic [7:0] anode, logic [31:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tuser <= kind;
        s_axis_tdata <= {now, anode, anet, phw, pnode, pnet};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(kind, pnet, pnode, phw, anet, anode, now);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_REFRESH:  refresh_s = val;
            CFG_RESOLVE:  resolve_s = val;
            CFG_RETRY:    retry_lim = val[3:0];
            CFG_OWN_NET:  own_net_r = val;
            CFG_OWN_NODE: own_node_r = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(negedge i_clk);
        repeat (3 * ENTRIES + 8) @(negedge i_clk);
    endtask

    // receiver side
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action = m_axis_tuser;
            got.slot = m_axis_tdata[3:0];
            got.dest_hw = m_axis_tdata[51:4];
            got.target_net = m_axis_tdata[67:52];
            got.target_node = m_axis_tdata[75:68];
            got.any_pending = m_axis_tdata[76];
            got.last = m_axis_tlast;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_outcomes.pop_front();
                if (got !== want || m_axis_tdata[79:77] !== 3'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_aarp_address_resolution_cache: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] pick_net();
        if (recent_net.size() != 0 && $urandom_range(3) != 0)
            return recent_net[$urandom_range(recent_net.size() - 1)];
        return $urandom_range(7) == 0 ? 16'hFFFF : 16'($urandom_range(3));
    endfunction

    task automatic test_directed();
        logic [31:0] t;
        t = 32'd1000;
        send_request(KIND_SEND, 16'h0001, 8'hFF, '0, '0, '0, t);     // broadcast node
        send_request(KIND_SEND, 16'h0001, 8'h05, '0, '0, '0, t);     // miss, allocates
        send_request(KIND_SEND, 16'h0001, 8'h05, '0, '0, '0, t);     // refused pending
        send_request(KIND_RESP, 16'h0009, 8'h09, 48'h1, '0, '0, t);  // stray response
        send_request(KIND_RESP, 16'h0001, 8'h05, 48'hFFFF_FFFF_FFFF, '0, '0, t);
        send_request(KIND_SEND, 16'h0001, 8'h05, '0, '0, '0, t);     // hit
        send_request(KIND_SEND, 16'hFFFF, 8'h00, '0, '0, '0, t);
        for (int i = 0; i < ENTRIES; i++)
            send_request(KIND_SEND, 16'h0100 + 16'(i), 8'h10, '0, '0, '0, t); // fills table
        send_request(KIND_REQ, 16'h0007, 8'h03, 48'hAAAA_5555_0F0F, 16'h0000, 8'h00, t);
        send_request(KIND_REQ, 16'h0007, 8'h03, 48'h1, 16'h0000, 8'h01, t);
        send_request(KIND_TICK, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);  // everything expired
        send_request(KIND_TICK, '0, '0, '0, '0, '0, 32'h0);
    endtask

    task automatic test_random(int count);
        int r;
        logic [15:0] net;
        logic [7:0]  node;
        logic [31:0] now;
        now = $urandom;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            now = now + $urandom_range(6);
            if ($urandom_range(40) == 0) now = $urandom;
            net = pick_net();
            node = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(5));
            if (r < 40) begin
                send_request(KIND_SEND, net, node, '0, 16'($urandom), 8'($urandom), now);
                if (recent_net.size() > 20) begin
                    recent_net.pop_front(); recent_node.pop_front();
                end
                recent_net.push_back(net); recent_node.push_back(node);
            end else if (r < 65) begin
                if (recent_net.size() != 0 && $urandom_range(3) != 0) begin
                    int k = $urandom_range(recent_net.size() - 1);
                    net = recent_net[k]; node = recent_node[k];
                end
                send_request(KIND_RESP, net, node, 48'({$urandom, $urandom}),
                             16'($urandom), 8'($urandom), now);
            end else if (r < 80) begin
                send_request(KIND_REQ, 16'($urandom), 8'($urandom),
                             48'({$urandom, $urandom}),
                             $urandom_range(1) ? own_net_r : 16'($urandom),
                             $urandom_range(2) != 0 ? own_node_r : 8'($urandom), now);
            end else
                send_request(KIND_TICK, 16'($urandom), 8'($urandom),
                             48'({$urandom, $urandom}),
                             16'($urandom), 8'($urandom), now);
        end
    endtask

    task automatic test_config(logic [15:0] refr, logic [15:0] resv, logic [3:0] lim,
                               logic [15:0] net, logic [7:0] node);
        drain();
        write_reg(CFG_REFRESH, refr);
        write_reg(CFG_RESOLVE, resv);
        write_reg(CFG_RETRY, {12'd0, lim});
        write_reg(CFG_OWN_NET, net);
        write_reg(CFG_OWN_NODE, {8'd0, node});
    endtask

    initial begin
        refresh_s = 16'd300; resolve_s = 16'd10; retry_lim = 4'd10;
        own_net_r = '0; own_node_r = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            ent_valid[i] = 1'b0; ent_res[i] = 1'b0; ent_net[i] = '0; ent_node[i] = '0;
            ent_hw[i] = '0; ent_exp[i] = '0; ent_tries[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 15; recv_idle_pct = 49;
        test_directed();
        test_random(60);
        test_config(16'd1, 16'd1, 4'd1, 16'hFFFF, 8'hFF);
        test_random(50);

        send_idle_pct = 49; recv_idle_pct = 15;
        test_config(16'hFFFF, 16'hFFFF, 4'd15, 16'h0000, 8'h00);
        test_random(50);
        test_config(16'd20, 16'd5, 4'd3, 16'h0002, 8'h03);
        test_random(50);

        send_idle_pct = 0; recv_idle_pct = 0;
        test_config(16'd8, 16'd30, 4'd2, 16'h8001, 8'h80);
        test_random(75);
        drain();
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("tb_aarp_address_resolution_cache: done, clean");
        else
            $display("tb_aarp_address_resolution_cache: done, errors");
        $finish;
    end
endmodule

/* sim.f */
rtl/aarp_pkg.sv
rtl/aarp_slot_cmp.sv
rtl/aarp_address_resolution_cache.sv
tb/tb_aarp_address_resolution_cache.sv
